>>> rtl/rational_power_free_checker_defines.svh
// ----------------------------------------------------------------------------
// rational_power_free_checker_defines.svh
// Assertion macros used by the checker file of the power-free checker.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_POWER_FREE_CHECKER_DEFINES_SVH
`define RATIONAL_POWER_FREE_CHECKER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define RPF_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define RPF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> rtl/rpf_pkg.sv
// ----------------------------------------------------------------------------
// rpf_pkg
// Types and constants of the streaming power-free word checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rpf_pkg;

  // Default sizing
  localparam int MAX_LEN_DEF     = 64;
  localparam int LETTER_BITS_DEF = 8;

  // Fixed field widths
  localparam int LETTER_W  = 8;
  localparam int WLEN_W    = 7;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POW_NUM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POW_DEN = 2'd1;

  // Register reset values (alpha = 5/4)
  localparam logic [CFG_W-1:0] POW_NUM_RST = 8'd5;
  localparam logic [CFG_W-1:0] POW_DEN_RST = 8'd4;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                first;
  } in_item_t;

  typedef struct packed {
    logic              is_free;
    logic [WLEN_W-1:0] word_length;
    logic              too_long;
  } out_item_t;

endpackage

>>> rtl/rpf_lane.sv
// ----------------------------------------------------------------------------
// rpf_lane
// One period lane: run counter of letters equal to the letter PERIOD back,
// and the exact exponent test den*(run+p) > num*p on a match.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rpf_lane #(
  parameter int MAX_LEN     = rpf_pkg::MAX_LEN_DEF,
  parameter int LETTER_BITS = rpf_pkg::LETTER_BITS_DEF,
  parameter int PERIOD      = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_en,
  input  logic                         word_start,
  input  logic                         active,
  input  logic [LETTER_BITS-1:0]       letter,
  input  logic [LETTER_BITS-1:0]       hist,
  input  logic [rpf_pkg::CFG_W-1:0]    pow_num,
  input  logic [rpf_pkg::CFG_W-1:0]    pow_den,
  output logic                         hit
);

  localparam int RUN_W  = $clog2(MAX_LEN);
  localparam int SUM_W  = RUN_W + 1;
  localparam int PROD_W = rpf_pkg::CFG_W + SUM_W;
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(MAX_LEN - 1);
  localparam logic [RUN_W-1:0] PER_C   = RUN_W'(PERIOD);

  logic [RUN_W-1:0]  run_r;
  logic [RUN_W-1:0]  run_nxt;
  logic [RUN_W-1:0]  run_upd;
  logic              match;
  logic [SUM_W-1:0]  run_sum;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;

  // Run update: saturating count on a match, cleared on a mismatch
  always_comb begin
    match   = (hist == letter);
    run_upd = '0;
    if (match) begin
      run_upd = (run_r < RUN_MAX) ? run_r + RUN_W'(1) : run_r;
    end
  end

  // Exponent test
  assign run_sum = SUM_W'(run_upd) + SUM_W'(PER_C);
  assign lhs     = PROD_W'(pow_den) * PROD_W'(run_sum);
  assign rhs     = PROD_W'(pow_num) * PROD_W'(PER_C);
  assign hit     = active && match && (lhs > rhs);

  // Counter next value
  always_comb begin
    run_nxt = run_r;
    if (step_en) begin
      if (word_start) begin
        run_nxt = '0;
      end else if (active) begin
        run_nxt = run_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= '0;
    end else begin
      run_r <= run_nxt;
    end
  end

endmodule

>>> rtl/rational_power_free_checker.sv
// ----------------------------------------------------------------------------
// rational_power_free_checker
// Streaming fractional-power-free test, one letter per transfer.
//
//   channel | direction | handshake            | payload
//   in_     | input     | in_valid / in_ready   | rpf_pkg::in_item_t
//   out_    | output    | out_valid / out_ready | rpf_pkg::out_item_t
//   cfg_    | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One letter per cycle sustained while out_ready holds; each letter passes the
// input register, then the result register. All MAX_LEN-1 period lanes test
// the letter in parallel against a shift line of past letters in the cycle it
// leaves the input register. Reset is synchronous and clears control state and
// run counters; the letter history needs none. An input transfer lands in the
// input register while a result waits; both stages hold on an output stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rational_power_free_checker #(
  parameter int MAX_LEN     = rpf_pkg::MAX_LEN_DEF,
  parameter int LETTER_BITS = rpf_pkg::LETTER_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  rpf_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output rpf_pkg::out_item_t            out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rpf_pkg::CFG_W-1:0]     cfg_data
);

  localparam int NPER  = MAX_LEN - 1;
  localparam int LEN_W = $clog2(MAX_LEN + 1);

  // Configuration registers
  logic [rpf_pkg::CFG_W-1:0] pow_num_r;
  logic [rpf_pkg::CFG_W-1:0] pow_den_r;

  // Pipeline registers
  logic                      in_v_r;
  rpf_pkg::in_item_t         in_r;
  logic                      out_v_r;
  rpf_pkg::out_item_t        out_r;
  logic                      proc;

  // Word state
  logic [LETTER_BITS-1:0]    hist_r [NPER];
  logic [LEN_W-1:0]          length_r;
  logic [LEN_W-1:0]          length_nxt;
  logic                      viol_r;
  logic                      viol_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;

  logic [LETTER_BITS-1:0]    letter_w;
  logic                      start;
  logic [LEN_W-1:0]          len_eff;
  logic                      sat;
  logic [NPER-1:0]           hits;

  // Configuration write port
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pow_num_r <= rpf_pkg::POW_NUM_RST;
      pow_den_r <= rpf_pkg::POW_DEN_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        rpf_pkg::CFG_POW_NUM: pow_num_r <= cfg_data;
        rpf_pkg::CFG_POW_DEN: pow_den_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: input stage advances when the result register is free
  assign proc     = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || proc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ready) begin
      in_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
  end

  // Current letter and word start
  assign letter_w = LETTER_BITS'(in_r.letter);
  assign start    = in_r.first;
  assign len_eff  = start ? '0 : length_r;
  assign sat      = (len_eff >= LEN_W'(MAX_LEN));

  // Period lanes
  for (genvar g = 1; g <= NPER; g++) begin : g_lane
    rpf_lane #(
      .MAX_LEN     (MAX_LEN),
      .LETTER_BITS (LETTER_BITS),
      .PERIOD      (g)
    ) u_lane (
      .clk        (clk),
      .rst_n      (rst_n),
      .step_en    (proc),
      .word_start (start),
      .active     (!start && (length_r >= LEN_W'(g))),
      .letter     (letter_w),
      .hist       (hist_r[g-1]),
      .pow_num    (pow_num_r),
      .pow_den    (pow_den_r),
      .hit        (hits[g-1])
    );
  end

  // Word state next values
  always_comb begin
    length_nxt = sat ? len_eff : len_eff + LEN_W'(1);
    viol_nxt   = (!start && viol_r) || (|hits);
    ovf_nxt    = sat || (!start && ovf_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
      viol_r   <= 1'b0;
      ovf_r    <= 1'b0;
    end else if (proc) begin
      length_r <= length_nxt;
      viol_r   <= viol_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  // Letter history shift line, most recent at index 0
  always_ff @(posedge clk) begin
    if (proc) begin
      hist_r[0] <= letter_w;
      for (int i = 1; i < NPER; i++) begin
        hist_r[i] <= hist_r[i-1];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proc) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_r.is_free     <= !viol_nxt;
      out_r.word_length <= rpf_pkg::WLEN_W'(length_nxt);
      out_r.too_long    <= ovf_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_data  = out_r;

endmodule

>>> rtl/rpf_checker.sv
// ----------------------------------------------------------------------------
// rpf_checker
// Port-level assertions for the power-free checker, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "rational_power_free_checker_defines.svh"

module rpf_checker #(
  parameter int MAX_LEN = rpf_pkg::MAX_LEN_DEF
) (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input rpf_pkg::out_item_t            out_data
);

  // A stalled result holds
  `RPF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data))

  // Input back-pressure only comes from a stalled, full pipeline
  `RPF_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)

  // An overflowed word reports the saturated length
  `RPF_ASSERT_IMPL(a_sat_len, out_valid && out_data.too_long,
                   out_data.word_length == rpf_pkg::WLEN_W'(MAX_LEN))

endmodule

bind rational_power_free_checker rpf_checker #(.MAX_LEN(MAX_LEN)) u_rpf_checker (.*);

>>> test/tb_rational_power_free_checker.sv
// ----------------------------------------------------------------------------
// tb_rational_power_free_checker
// Self-checking bench for the streaming fractional-power-free word checker.
// A short table of hand-picked letters comes first, some with pinned verdicts.
// Random words follow (full-range, small-alphabet and periodic with mutations)
// under a series of alpha settings. Every result transfer is checked field by
// field against its pinned verdict, else an in-bench tracker of the word history and the per-period run counters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rational_power_free_checker;

  localparam int MAXW        = rpf_pkg::MAX_LEN_DEF;
  localparam int NPER        = MAXW - 1;
  localparam int PHASE_ITEMS = 128;
  localparam int N_ALPHA     = 9;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_AT     = 300;
  localparam int HOLD_LEN    = 80;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [rpf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd2;

  typedef struct {
    rpf_pkg::in_item_t  item;
    bit                 pinned;
    rpf_pkg::out_item_t verdict;
  } probe_t;

  typedef struct {
    logic [rpf_pkg::CFG_W-1:0] num;
    logic [rpf_pkg::CFG_W-1:0] den;
  } alpha_t;

  logic                          clk       = 1'b0;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  rpf_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  rpf_pkg::out_item_t            out_data;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [rpf_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rpf_pkg::CFG_W-1:0]     cfg_data  = '0;

  // Word tracker state
  logic [rpf_pkg::LETTER_W-1:0] seen_letters [NPER] = '{default: '0};
  logic [5:0]                   match_run    [NPER] = '{default: '0};
  logic [rpf_pkg::WLEN_W-1:0]   word_len  = '0;
  bit                           hit_power = 1'b0;
  bit                           past_max  = 1'b0;
  logic [rpf_pkg::CFG_W-1:0]    exp_num   = rpf_pkg::POW_NUM_RST;
  logic [rpf_pkg::CFG_W-1:0]    exp_den   = rpf_pkg::POW_DEN_RST;

  rpf_pkg::out_item_t expected_verdicts [$];
  int                 send_idle_pct = 17;
  int                 recv_idle_pct = 47;
  int                 err_cnt       = 0;
  int                 cycles        = 0;

  // Hand-picked letters under the reset alpha of 5/4
  probe_t probes [17] = '{
    '{'{8'h00, 1'b0}, 1'b1, '{1'b1, 7'd1, 1'b0}},  // first letter after reset
    '{'{8'hFF, 1'b0}, 1'b1, '{1'b1, 7'd2, 1'b0}},
    '{'{8'hFF, 1'b0}, 1'b1, '{1'b0, 7'd3, 1'b0}},  // square of one letter
    '{'{8'hFF, 1'b0}, 1'b0, '0},                    // violation is sticky
    '{'{8'h55, 1'b1}, 1'b1, '{1'b1, 7'd1, 1'b0}},  // new word clears it
    '{'{8'hAA, 1'b0}, 1'b0, '0},
    '{'{8'h55, 1'b0}, 1'b0, '0},
    '{'{8'hAA, 1'b1}, 1'b1, '{1'b1, 7'd1, 1'b0}},
    '{'{8'h01, 1'b0}, 1'b0, '0},
    '{'{8'h02, 1'b0}, 1'b0, '0},
    '{'{8'h80, 1'b0}, 1'b0, '0},
    '{'{8'h01, 1'b0}, 1'b0, '0},
    '{'{8'h7F, 1'b1}, 1'b1, '{1'b1, 7'd1, 1'b0}},
    '{'{8'hFE, 1'b0}, 1'b0, '0},
    '{'{8'h7F, 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b1, '{1'b1, 7'd1, 1'b0}},
    '{'{8'h00, 1'b0}, 1'b1, '{1'b0, 7'd2, 1'b0}}
  };

  // Alpha settings walked by the random part: ordinary, extremes, zero edges
  alpha_t alphas [N_ALPHA] = '{
    '{8'd2,   8'd1},
    '{8'd7,   8'd4},
    '{8'd1,   8'd1},
    '{8'd255, 8'd1},
    '{8'd1,   8'd255},
    '{8'd255, 8'd255},
    '{8'd7,   8'd3},
    '{8'd0,   8'd9},
    '{8'd3,   8'd0}
  };

  rational_power_free_checker dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Advance the word tracker by one letter and return the verdict it implies
  function automatic rpf_pkg::out_item_t track_letter(input rpf_pkg::in_item_t it);
    int                 lim;
    rpf_pkg::out_item_t v;
    if (it.first) begin
      foreach (match_run[i]) match_run[i] = '0;
      word_len  = '0;
      hit_power = 1'b0;
      past_max  = 1'b0;
    end
    lim = (word_len < NPER) ? int'(word_len) : NPER;
    // all periods within the current word
    for (int p = 1; p <= lim; p++) begin
      if (seen_letters[p-1] == it.letter) begin
        if (match_run[p-1] < NPER) match_run[p-1] = match_run[p-1] + 1'b1;
        if (int'(exp_den) * (int'(match_run[p-1]) + p) > int'(exp_num) * p)
          hit_power = 1'b1;
      end else begin
        match_run[p-1] = '0;
      end
    end
    for (int i = NPER - 1; i > 0; i--) seen_letters[i] = seen_letters[i-1];
    seen_letters[0] = it.letter;
    if (word_len >= MAXW) past_max = 1'b1;
    else word_len = word_len + 1'b1;
    v.is_free     = !hit_power;
    v.word_length = word_len;
    v.too_long    = past_max;
    return v;
  endfunction

  // One input transfer; the tracker advances when the letter is taken
  task automatic push_letter(input rpf_pkg::in_item_t it, input bit pinned,
                             input rpf_pkg::out_item_t pinned_v);
    rpf_pkg::out_item_t v;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    v = track_letter(it);
    expected_verdicts.push_back(pinned ? pinned_v : v);
  endtask

  // Register write; valid drops after each transfer
  task automatic write_reg(input logic [rpf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rpf_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == rpf_pkg::CFG_POW_NUM) exp_num = val;
    else if (idx == rpf_pkg::CFG_POW_DEN) exp_den = val;
    @(posedge clk);
  endtask

  // Stop offering letters and let the pipeline empty
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Result side: check each transfer, then pick the next ready
  int done_cnt   = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    rpf_pkg::out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_verdicts.size() == 0) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("unexpected result: free=%0d len=%0d long=%0d",
                     out_data.is_free, out_data.word_length, out_data.too_long);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.is_free !== want.is_free ||
              out_data.word_length !== want.word_length ||
              out_data.too_long !== want.too_long) begin
            err_cnt++;
            if (err_cnt <= 10)
              $display("mismatch: expected free=%0d len=%0d long=%0d, %s",
                       want.is_free, want.word_length, want.too_long,
                       $sformatf("got free=%0d len=%0d long=%0d", out_data.is_free,
                                 out_data.word_length, out_data.too_long));
          end
        end
        done_cnt++;
        // long hold-off once, so the block fills and stalls its input
        if (done_cnt == HOLD_AT) stall_left = HOLD_LEN;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Stimulus
  initial begin
    int                           sent;
    int                           kind;
    int                           wlen;
    int                           base_len;
    logic [rpf_pkg::LETTER_W-1:0] base [12];
    rpf_pkg::in_item_t            it;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (probes[r]) push_letter(probes[r].item, probes[r].pinned, probes[r].verdict);

    for (int ph = 0; ph < N_ALPHA; ph++) begin
      drain();
      write_reg(rpf_pkg::CFG_POW_NUM, alphas[ph].num);
      write_reg(rpf_pkg::CFG_POW_DEN, alphas[ph].den);
      if (ph == 4) write_reg(CFG_SPARE, 8'hA5);
      // idle mix: sender light / receiver heavy, then swapped, then none
      if (ph < 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 47;
      end else if (ph < 6) begin
        send_idle_pct = 47;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // word shape: 0-2 random, 3-5 small alphabet, 6-9 periodic
        kind = $urandom_range(0, 9);
        wlen = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 90) : $urandom_range(1, 24);
        if (kind < 3) base_len = 0;
        else if (kind < 6) base_len = $urandom_range(2, 4);
        else base_len = $urandom_range(1, 12);
        foreach (base[j]) base[j] = rpf_pkg::LETTER_W'($urandom_range(0, 255));
        for (int i = 0; i < wlen; i++) begin
          if (kind < 3) it.letter = rpf_pkg::LETTER_W'($urandom_range(0, 255));
          else if (kind < 6) it.letter = base[$urandom_range(0, base_len - 1)];
          else if ($urandom_range(0, 15) == 0)
            it.letter = rpf_pkg::LETTER_W'($urandom_range(0, 255));
          else it.letter = base[i % base_len];
          // mostly well-formed word starts, some merged or split words
          it.first = (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 49) == 0);
          push_letter(it, 1'b0, '0);
          sent++;
        end
      end
    end

    drain();
    repeat (6) @(posedge clk);
    if (err_cnt == 0 && expected_verdicts.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
